FILE: sv/pem_pkg.sv
// shared types and constants for the power and energy meter
package pem_pkg;

  localparam logic [47:0] E48_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [9:0]  EFF_FULL = 10'd1000;
  localparam logic [10:0] PF_ONE   = 11'd1024;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [1:0] REG_MAINS_VOLTAGE   = 2'd0;
  localparam logic [1:0] REG_MIN_INTERVAL    = 2'd1;
  localparam logic [1:0] REG_EFF_MIN_POWER   = 2'd2;
  localparam logic [1:0] REG_PF_MIN_CURRENT  = 2'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] time_ms;
    logic [15:0] main_power;
    logic [15:0] output_power;
    logic [15:0] main_current;
    logic        new_day;
    logic        new_month;
  } pem_in_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] instant_power;
    logic [15:0] average_power;
    logic [15:0] peak_power;
    logic [47:0] daily_energy;
    logic [47:0] monthly_energy;
    logic        month_closed;
    logic [47:0] closed_month_energy;
    logic [9:0]  efficiency;
    logic [10:0] power_factor;
    logic [31:0] elapsed_ms;
  } pem_out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_E,
    ST_ADD_E,
    ST_MUL_EFF,
    ST_DIV_EFF,
    ST_MUL_APP,
    ST_MUL_PF,
    ST_DIV_PF,
    ST_SUM,
    ST_DIV_AVG,
    ST_OUT
  } pem_state_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [47:0] den;
  } pem_div_req_t;

endpackage

FILE: sv/power_energy_metering.sv
// top level: power and energy meter with a sequenced shared datapath
// clear, first or rejected samples go straight to the result; an accepted sample
// sums its filled ring entries one by one and runs three divisions in turn on the
// shared divider; efficiency or power factor at or below threshold skips that division
// one request at a time: in_stall stays high until the result is taken
// reset is synchronous and clears statistics, ring count and registers to defaults
module power_energy_metering import pem_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pem_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pem_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  logic [15:0] mains_voltage, min_interval_ms, efficiency_min_power, pf_min_current;

  logic        started;
  logic [31:0] start_time, last_time;
  logic [47:0] total_energy, daily_base, monthly_base;
  logic [15:0] peak_value, last_power;
  logic [15:0] power_ring [RING_DEPTH];
  logic [IW-1:0] ring_index;
  logic        ring_full;
  logic [9:0]  last_efficiency;
  logic [10:0] last_power_factor;

  pem_state_t  state, state_next;
  pem_in_t     req;
  logic [31:0] delta;
  logic [47:0] acc;
  logic [47:0] prod;
  logic [IW-1:0] sum_idx;
  logic [CW-1:0] count;
  logic        accepted;
  logic        closed;
  logic [47:0] closed_energy;
  pem_div_req_t dreq;
  logic        dbusy;
  logic [47:0] dquot;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || out_valid;
  assign count = ring_full ? CW'(RING_DEPTH) : CW'(ring_index);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mains_voltage        <= 16'd2300;
      min_interval_ms      <= 16'd100;
      efficiency_min_power <= 16'd100;
      pf_min_current       <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAINS_VOLTAGE:  mains_voltage        <= cfg_data;
        REG_MIN_INTERVAL:   min_interval_ms      <= cfg_data;
        REG_EFF_MIN_POWER:  efficiency_min_power <= cfg_data;
        REG_PF_MIN_CURRENT: pf_min_current       <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    dreq = '0;
    case (state)
      ST_IDLE: if (in_valid && !in_stall) begin
        if (in_data.command == CMD_SAMPLE && started
            && (in_data.time_ms - last_time) >= {16'd0, min_interval_ms})
          state_next = ST_MUL_E;
        else
          state_next = ST_OUT;
      end
      ST_MUL_E:   state_next = ST_ADD_E;
      ST_ADD_E:   state_next = ST_MUL_EFF;
      ST_MUL_EFF: begin
        if (req.main_power > efficiency_min_power && req.main_power != 16'd0) begin
          dreq.start = 1'b1;
          dreq.num = prod;
          dreq.den = {32'd0, req.main_power};
          state_next = ST_DIV_EFF;
        end else begin
          state_next = ST_MUL_APP;
        end
      end
      ST_DIV_EFF: if (!dbusy) state_next = ST_MUL_APP;
      ST_MUL_APP: state_next = ST_MUL_PF;
      ST_MUL_PF: begin
        if (req.main_current > pf_min_current && acc != 48'd0) begin
          dreq.start = 1'b1;
          dreq.num = prod;
          dreq.den = acc;
          state_next = ST_DIV_PF;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_DIV_PF: if (!dbusy) state_next = ST_SUM;
      ST_SUM: if (sum_idx == IW'(count - CW'(1))) begin
        dreq.start = 1'b1;
        dreq.num = acc + {32'd0, power_ring[sum_idx]};
        dreq.den = {{(48-CW){1'b0}}, count};
        state_next = ST_DIV_AVG;
      end
      ST_DIV_AVG: if (!dbusy) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  pem_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dquot));

  // datapath and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      start_time <= '0;
      last_time <= '0;
      total_energy <= '0;
      daily_base <= '0;
      monthly_base <= '0;
      peak_value <= '0;
      last_power <= '0;
      ring_index <= '0;
      ring_full <= 1'b0;
      last_efficiency <= '0;
      last_power_factor <= PF_ONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          req <= in_data;
          delta <= in_data.time_ms - last_time;
          accepted <= 1'b0;
          closed <= 1'b0;
          closed_energy <= '0;
          if (in_data.command == CMD_CLEAR) begin
            total_energy <= '0; daily_base <= '0; monthly_base <= '0;
            peak_value <= '0; last_power <= '0; ring_index <= '0;
            ring_full <= 1'b0; last_efficiency <= '0;
            last_power_factor <= PF_ONE;
            started <= 1'b1;
            start_time <= in_data.time_ms;
            last_time <= in_data.time_ms;
          end else begin
            if (in_data.new_day) daily_base <= total_energy;
            if (in_data.new_month) begin
              closed <= 1'b1;
              closed_energy <= total_energy - monthly_base;
              monthly_base <= total_energy;
            end
            if (!started) begin
              started <= 1'b1;
              start_time <= in_data.time_ms;
              last_time <= in_data.time_ms;
            end
          end
        end
        ST_MUL_E: begin
          prod <= {16'd0, req.main_power} * {16'd0, delta};
          accepted <= 1'b1;
          last_power <= req.main_power;
          power_ring[ring_index] <= req.main_power;
          if (ring_index == IW'(RING_DEPTH - 1)) begin
            ring_index <= '0;
            ring_full <= 1'b1;
          end else begin
            ring_index <= ring_index + IW'(1);
          end
          if (req.main_power > peak_value) peak_value <= req.main_power;
          last_time <= req.time_ms;
        end
        ST_ADD_E: begin
          if (prod > E48_MAX - total_energy) total_energy <= E48_MAX;
          else total_energy <= total_energy + prod;
          prod <= {32'd0, req.output_power} * 48'd1000;
        end
        ST_MUL_EFF: if (state_next == ST_MUL_APP) last_efficiency <= '0;
        ST_DIV_EFF: if (!dbusy)
          last_efficiency <= (dquot > 48'd1000) ? EFF_FULL : dquot[9:0];
        ST_MUL_APP: begin
          acc <= {32'd0, req.main_current} * {32'd0, mains_voltage};
          prod <= {32'd0, req.main_power} * 48'd1024000;
        end
        ST_MUL_PF: begin
          if (state_next == ST_SUM) last_power_factor <= PF_ONE;
          if (state_next == ST_SUM) begin acc <= '0; sum_idx <= '0; end
        end
        ST_DIV_PF: if (!dbusy) begin
          last_power_factor <= (dquot > 48'd1024) ? PF_ONE : dquot[10:0];
          acc <= '0;
          sum_idx <= '0;
        end
        ST_SUM: begin
          acc <= acc + {32'd0, power_ring[sum_idx]};
          sum_idx <= sum_idx + IW'(1);
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          out_data.accepted <= accepted;
          out_data.instant_power <= last_power;
          out_data.average_power <= (count == '0) ? 16'd0
                                   : (accepted ? dquot[15:0] : out_data.average_power);
          out_data.peak_power <= peak_value;
          out_data.daily_energy <= total_energy - daily_base;
          out_data.monthly_energy <= total_energy - monthly_base;
          out_data.month_closed <= closed;
          out_data.closed_month_energy <= closed_energy;
          out_data.efficiency <= last_efficiency;
          out_data.power_factor <= last_power_factor;
          out_data.elapsed_ms <= req.time_ms - start_time;
        end
        default: ;
      endcase
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT)) else $error("stray result");
  a_eff_range: assert property (@(posedge clk) disable iff (rst)
    last_efficiency <= EFF_FULL) else $error("efficiency out of range");
  a_pf_range: assert property (@(posedge clk) disable iff (rst)
    last_power_factor <= PF_ONE) else $error("power factor out of range");

endmodule

FILE: sv/pem_div.sv
// shared restoring divider, one quotient bit per cycle
module pem_div import pem_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  pem_div_req_t req,
  output logic         busy,
  output logic [47:0]  quot
);

  logic [47:0] rem;
  logic [47:0] den;
  logic [5:0]  cnt;
  logic [48:0] trial;

  assign trial = {rem, quot[47]} - {1'b0, den};

  // shift-subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'd48;
      rem  <= '0;
      quot <= req.num;
      den  <= req.den;
    end else if (busy) begin
      if (!trial[48]) begin
        rem  <= trial[47:0];
        quot <= {quot[46:0], 1'b1};
      end else begin
        rem  <= {rem[46:0], quot[47]};
        quot <= {quot[46:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

endmodule

FILE: tb/tb.sv
// self-checking bench for the power and energy meter with a built-in predictor
module tb;
  import pem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_N     = 16;
  localparam int LIMIT      = 3000000;
  localparam int DRAIN      = 400;
  localparam int NUM_PHASES = 6;
  localparam int RAND_ITEMS = 130;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pem_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pem_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MAINS_VOLTAGE;
  logic [15:0] cfg_data = '0;

  power_energy_metering #(.RING_DEPTH(RING_N)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of registers and statistics
  logic [15:0] voltage_q, interval_q, eff_floor_q, pf_floor_q;
  logic        started_q;
  logic [31:0] start_t, last_t;
  logic [47:0] total_e, day_base, month_base;
  logic [15:0] peak_q, last_pw;
  logic [15:0] ring_q [RING_N];
  int          ring_pos;
  logic        ring_full_q;
  logic [9:0]  eff_q;
  logic [10:0] pf_q;

  pem_in_t  pending_samples[$];
  pem_out_t pending_results[$];
  int       errors = 0;
  int       snd_idle = 0;
  int       rcv_stall = 0;
  logic [31:0] t_cursor = 32'd0;

  function automatic void clear_stats();
    total_e = '0; day_base = '0; month_base = '0;
    peak_q = '0; last_pw = '0;
    for (int i = 0; i < RING_N; i++) ring_q[i] = '0;
    ring_pos = 0; ring_full_q = 1'b0;
    eff_q = '0; pf_q = PF_ONE;
  endfunction

  function automatic pem_out_t meter_predict(pem_in_t r);
    pem_out_t    o;
    logic [31:0] dt;
    logic [63:0] inc, q, app, sum;
    int          cnt;
    o = '0;
    if (r.command == CMD_CLEAR) begin
      clear_stats();
      started_q = 1'b1; start_t = r.time_ms; last_t = r.time_ms;
    end else begin
      if (r.new_day) day_base = total_e;
      if (r.new_month) begin
        o.month_closed = 1'b1;
        o.closed_month_energy = total_e - month_base;
        month_base = total_e;
      end
      if (!started_q) begin
        started_q = 1'b1; start_t = r.time_ms; last_t = r.time_ms;
      end else begin
        dt = r.time_ms - last_t;
        if (dt >= {16'd0, interval_q}) begin
          o.accepted = 1'b1;
          inc = 64'(r.main_power) * 64'(dt);
          last_pw = r.main_power;
          ring_q[ring_pos] = r.main_power;
          ring_pos++;
          if (ring_pos >= RING_N) begin
            ring_pos = 0; ring_full_q = 1'b1;
          end
          if (r.main_power > peak_q) peak_q = r.main_power;
          if (inc > 64'(E48_MAX - total_e)) total_e = E48_MAX;
          else total_e = total_e + inc[47:0];
          // efficiency
          if (r.main_power > eff_floor_q && r.main_power != 0) begin
            q = (64'(r.output_power) * 64'd1000) / 64'(r.main_power);
            eff_q = (q > 64'd1000) ? EFF_FULL : q[9:0];
          end else eff_q = '0;
          // power factor
          app = 64'(r.main_current) * 64'(voltage_q);
          if (r.main_current > pf_floor_q && app != 0) begin
            q = (64'(r.main_power) * 64'd1024000) / app;
            pf_q = (q > 64'd1024) ? PF_ONE : q[10:0];
          end else pf_q = PF_ONE;
          last_t = r.time_ms;
        end
      end
    end
    cnt = ring_full_q ? RING_N : ring_pos;
    sum = '0;
    for (int i = 0; i < cnt; i++) sum += 64'(ring_q[i]);
    o.instant_power  = last_pw;
    o.average_power  = (cnt == 0) ? 16'd0 : 16'(sum / 64'(cnt));
    o.peak_power     = peak_q;
    o.daily_energy   = total_e - day_base;
    o.monthly_energy = total_e - month_base;
    o.efficiency     = eff_q;
    o.power_factor   = pf_q;
    o.elapsed_ms     = r.time_ms - start_t;
    return o;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        pending_results = {pending_results, meter_predict(in_data)};
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pem_out_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $time, out_data);
        end else begin
          e = pending_results.pop_front();
          check_field("accepted", e.accepted, out_data.accepted);
          check_field("instant_power", e.instant_power, out_data.instant_power);
          check_field("average_power", e.average_power, out_data.average_power);
          check_field("peak_power", e.peak_power, out_data.peak_power);
          check_field("daily_energy", e.daily_energy, out_data.daily_energy);
          check_field("monthly_energy", e.monthly_energy, out_data.monthly_energy);
          check_field("month_closed", e.month_closed, out_data.month_closed);
          check_field("closed_month_energy", e.closed_month_energy,
                      out_data.closed_month_energy);
          check_field("efficiency", e.efficiency, out_data.efficiency);
          check_field("power_factor", e.power_factor, out_data.power_factor);
          check_field("elapsed_ms", e.elapsed_ms, out_data.elapsed_ms);
        end
      end
      out_stall <= ($urandom_range(0, 99) < rcv_stall);
    end
  end

  // cycle limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic pem_in_t mk(logic cmd, logic [31:0] dt, logic [15:0] pin,
                                 logic [15:0] pout, logic [15:0] cur,
                                 logic nd, logic nm);
    pem_in_t r;
    t_cursor = t_cursor + dt;
    r.command = cmd; r.time_ms = t_cursor;
    r.main_power = pin; r.output_power = pout; r.main_current = cur;
    r.new_day = nd; r.new_month = nm;
    return r;
  endfunction

  // append a request to the driver queue
  function automatic void queue_sample(pem_in_t r);
    pending_samples = {pending_samples, r};
  endfunction

  // field value biased toward extremes and a threshold
  function automatic logic [15:0] pick16(logic [15:0] pivot);
    int s;
    s = $urandom_range(0, 99);
    if (s < 8) return 16'd0;
    if (s < 16) return 16'hFFFF;
    if (s < 30) return pivot + 16'($urandom_range(0, 2)) - 16'd1;
    if (s < 60) return 16'($urandom_range(0, 4000));
    return 16'($urandom);
  endfunction

  function automatic pem_in_t rand_item();
    int          s;
    logic [31:0] dt;
    s = $urandom_range(0, 99);
    if (s < 70) dt = 32'(interval_q) + 32'($urandom_range(0, 300));
    else if (s < 82) dt = (interval_q == 0) ? 32'd0 : 32'($urandom_range(0, interval_q - 1));
    else if (s < 92) dt = $urandom;
    else dt = 32'($urandom_range(0, 20));
    return mk(($urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_SAMPLE, dt,
              pick16(eff_floor_q), pick16(eff_floor_q), pick16(pf_floor_q),
              ($urandom_range(0, 7) == 0), ($urandom_range(0, 9) == 0));
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAINS_VOLTAGE: voltage_q   = val;
      REG_MIN_INTERVAL:  interval_q  = val;
      REG_EFF_MIN_POWER: eff_floor_q = val;
      default:           pf_floor_q  = val;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || pending_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [15:0] cv [NUM_PHASES][4];
    int          idle_s [NUM_PHASES];
    int          idle_r [NUM_PHASES];
    voltage_q = 16'd2300; interval_q = 16'd100; eff_floor_q = 16'd100; pf_floor_q = 16'd100;
    started_q = 1'b0; start_t = '0; last_t = '0;
    clear_stats();
    cv[0] = '{16'd2300, 16'd100, 16'd100, 16'd100};   idle_s[0] = 0;  idle_r[0] = 0;
    cv[1] = '{16'd1, 16'd0, 16'd0, 16'd0};            idle_s[1] = 53; idle_r[1] = 0;
    cv[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; idle_s[2] = 0;  idle_r[2] = 53;
    cv[3] = '{16'd0, 16'd7, 16'd1000, 16'd50};        idle_s[3] = 35; idle_r[3] = 35;
    cv[4] = '{16'($urandom), 16'($urandom_range(0, 500)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 3000))};          idle_s[4] = 0;  idle_r[4] = 0;
    cv[5] = '{16'd2300, 16'd100, 16'd100, 16'd100};   idle_s[5] = 35; idle_r[5] = 35;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: first sample, rejection, extremes, clamps, flags, wrap, saturation
    queue_sample(mk(CMD_SAMPLE, 32'd1000, 16'd500, 16'd400, 16'd500, 1'b1, 1'b1));
    queue_sample(mk(CMD_SAMPLE, 32'd50, 16'd500, 16'd400, 16'd500, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd150, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd100, 16'd200, 16'd1000, 16'd101, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd100, 16'd100, 16'd90, 16'd100, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd101, 16'd101, 16'd90, 16'd5000, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd10, 16'd300, 16'd200, 16'd300, 1'b1, 1'b1));
    queue_sample(mk(CMD_SAMPLE, 32'd200, 16'd300, 16'd200, 16'd300, 1'b0, 1'b1));
    queue_sample(mk(CMD_SAMPLE, 32'hFFFF_FF00 - t_cursor, 16'd700, 16'd600,
                    16'd1000, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd400, 16'd700, 16'd600, 16'd1000, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'd2000, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'd2000, 1'b1, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'd2000, 1'b0, 1'b0));
    queue_sample(mk(CMD_SAMPLE, 32'd100, 16'd10, 16'd1, 16'd2000, 1'b1, 1'b1));
    queue_sample(mk(CMD_CLEAR, 32'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    queue_sample(mk(CMD_SAMPLE, 32'd100, 16'd1234, 16'd999, 16'd700, 1'b0, 1'b0));
    for (int i = 0; i < 18; i++)
      queue_sample(mk(CMD_SAMPLE, 32'd100 + 32'(i), 16'(100 * i + 7), 16'(50 * i),
                      16'(200 + i), 1'b0, 1'b0));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        cfg_write(REG_MAINS_VOLTAGE, cv[p][0]);
        cfg_write(REG_MIN_INTERVAL, cv[p][1]);
        cfg_write(REG_EFF_MIN_POWER, cv[p][2]);
        cfg_write(REG_PF_MIN_CURRENT, cv[p][3]);
      end
      snd_idle = idle_s[p];
      rcv_stall = idle_r[p];
      for (int i = 0; i < RAND_ITEMS; i++) queue_sample(rand_item());
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: power_energy_metering.f
sv/pem_pkg.sv
sv/pem_div.sv
sv/power_energy_metering.sv
tb/tb.sv
